[hdl/ugs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugs_pkg
// Shared types, codes and constants of the ultrasonic gate stopwatch.
// ----------------------------------------------------------------------------
package ugs_pkg;

	// parameter defaults
	localparam int SENSOR_COUNT_DEF  = 4;
	localparam int CAPTURE_WIDTH_DEF = 16;

	// field widths
	localparam int OP_W      = 3;
	localparam int CH_W      = 2;
	localparam int CAP_FLD_W = 16;
	localparam int NOW_W     = 32;
	localparam int COUNT_W   = 32;
	localparam int PHASE_W   = 2;
	localparam int LAMP_W    = 3;

	// configuration widths
	localparam int PERIOD_W  = 17;
	localparam int TICKS_W   = 8;
	localparam int NEAR_W    = 10;
	localparam int MS_W      = 16;
	localparam int LIMIT_W   = TICKS_W + NEAR_W;
	localparam int SPAN_W    = LIMIT_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = PERIOD_W;

	// stream widths
	localparam int IN_TDATA_W  = 56;
	localparam int IN_TUSER_W  = OP_W;
	localparam int OUT_TDATA_W = 40;

	// channels past the capture index range can never be captured
	localparam int CH_LIMIT = 4;
	// number of channels with an indicator lamp
	localparam int LAMP_COUNT = 3;

	// configuration reset values
	localparam logic [PERIOD_W-1:0] PERIOD_RST   = 17'd10000;
	localparam logic [TICKS_W-1:0]  TICKS_RST    = 8'd58;
	localparam logic [NEAR_W-1:0]   NEAR_RST     = 10'd30;
	localparam logic [MS_W-1:0]     HOLDOFF_RST  = 16'd2000;
	localparam logic [MS_W-1:0]     DEBOUNCE_RST = 16'd200;

	// item operations
	typedef enum logic [OP_W-1:0] {
		OP_CAPTURE = 3'd0,
		OP_TICK    = 3'd1,
		OP_EVAL    = 3'd2,
		OP_BUTTON  = 3'd3,
		OP_CLEAR   = 3'd4
	} op_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMER_PERIOD = 3'd0,
		CFG_TICKS_PER_CM = 3'd1,
		CFG_NEAR_LIMIT   = 3'd2,
		CFG_HOLDOFF      = 3'd3,
		CFG_DEBOUNCE     = 3'd4
	} cfg_idx_t;

	// per-channel capture progress
	typedef enum logic [2:0] {
		CS_NONE  = 3'b001,
		CS_START = 3'b010,
		CS_BOTH  = 3'b100
	} cap_stage_t;

	// start/stop sequencer
	typedef enum logic [3:0] {
		PH_ARMED   = 4'b0001,
		PH_RUNNING = 4'b0010,
		PH_STOPPED = 4'b0100,
		PH_CLEARED = 4'b1000
	} phase_t;

	// reported phase codes
	localparam logic [PHASE_W-1:0] PHC_ARMED   = 2'd0;
	localparam logic [PHASE_W-1:0] PHC_RUNNING = 2'd1;
	localparam logic [PHASE_W-1:0] PHC_STOPPED = 2'd2;
	localparam logic [PHASE_W-1:0] PHC_CLEARED = 2'd3;

	// one input request
	typedef struct packed {
		op_t                  op;
		logic [CH_W-1:0]      channel;
		logic [CAP_FLD_W-1:0] capture_value;
		logic [NOW_W-1:0]     now_ms;
	} item_t;

	// one result
	typedef struct packed {
		logic               running;
		logic [COUNT_W-1:0] elapsed_count;
		logic [PHASE_W-1:0] phase;
		logic [LAMP_W-1:0]  led_mask;
		logic               report;
		logic               presence;
	} result_t;

	// settings seen by the core
	typedef struct packed {
		logic [PERIOD_W-1:0] timer_period;
		logic [LIMIT_W-1:0]  limit;
		logic [MS_W-1:0]     holdoff_ms;
		logic [MS_W-1:0]     debounce_ms;
	} cfg_t;

	// one-hot phase to reported code
	function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
		logic [PHASE_W-1:0] code;
		unique case (ph)
			PH_ARMED:   code = PHC_ARMED;
			PH_RUNNING: code = PHC_RUNNING;
			PH_STOPPED: code = PHC_STOPPED;
			PH_CLEARED: code = PHC_CLEARED;
			default:    code = PHC_ARMED;
		endcase
		return code;
	endfunction

endpackage

[hdl/ugs_near_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugs_near_check
// Pulse width of one echo channel with wrap at the timer period, and the
// near test against the distance limit in timer ticks.
// ----------------------------------------------------------------------------
module ugs_near_check #(
	parameter int CAP_W = ugs_pkg::CAPTURE_WIDTH_DEF
) (
	input  ugs_pkg::cap_stage_t           stage,
	input  logic [CAP_W-1:0]              echo_begin,
	input  logic [CAP_W-1:0]              echo_finish,
	input  logic [ugs_pkg::PERIOD_W-1:0]  timer_period,
	input  logic [ugs_pkg::LIMIT_W-1:0]   limit,
	output logic                          near
);

	logic [ugs_pkg::SPAN_W-1:0] begin_x;
	logic [ugs_pkg::SPAN_W-1:0] finish_x;
	logic [ugs_pkg::SPAN_W-1:0] period_x;
	logic [ugs_pkg::SPAN_W-1:0] span;

	assign begin_x  = ugs_pkg::SPAN_W'(echo_begin);
	assign finish_x = ugs_pkg::SPAN_W'(echo_finish);
	assign period_x = ugs_pkg::SPAN_W'(timer_period);

	// width, going through the timer wrap when the end is below the start
	always_comb begin
		if (echo_finish >= echo_begin) begin
			span = finish_x - begin_x;
		end else begin
			span = period_x - begin_x + finish_x;
		end
	end

	// signed width strictly between zero and the limit
	assign near = (stage == ugs_pkg::CS_BOTH)
		&& ($signed(span) > $signed(ugs_pkg::SPAN_W'(0)))
		&& ($signed(span) < $signed(ugs_pkg::SPAN_W'(limit)));

endmodule

[hdl/ugs_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugs_core
// Gate state: echo captures, presence scan with hold-off, start/stop
// sequencer, stopwatch count, indicator lamps. One request per cycle with go.
// ----------------------------------------------------------------------------
module ugs_core #(
	parameter int SENSOR_COUNT  = ugs_pkg::SENSOR_COUNT_DEF,
	parameter int CAPTURE_WIDTH = ugs_pkg::CAPTURE_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  ugs_pkg::item_t   item,
	input  ugs_pkg::cfg_t    cfg,
	output ugs_pkg::result_t result
);

	// channels that can ever hold a capture, and stored capture width
	localparam int NCH   = (SENSOR_COUNT < ugs_pkg::CH_LIMIT) ? SENSOR_COUNT
		: ugs_pkg::CH_LIMIT;
	localparam int CAP_W = (CAPTURE_WIDTH < ugs_pkg::CAP_FLD_W) ? CAPTURE_WIDTH
		: ugs_pkg::CAP_FLD_W;

	logic [NCH-1:0] near;

	logic                          presence_q;
	ugs_pkg::phase_t               phase_q;
	logic                          counting_q;
	logic [ugs_pkg::COUNT_W-1:0]   tick_q;
	logic [ugs_pkg::NOW_W-1:0]     event_ms_q;
	logic [ugs_pkg::CH_W-1:0]      lit_q;
	logic [ugs_pkg::LAMP_W-1:0]    lamp_q;

	logic                          presence_n;
	ugs_pkg::phase_t               phase_n;
	logic                          counting_n;
	logic [ugs_pkg::COUNT_W-1:0]   tick_n;
	logic [ugs_pkg::NOW_W-1:0]     event_ms_n;
	logic [ugs_pkg::CH_W-1:0]      lit_n;
	logic [ugs_pkg::LAMP_W-1:0]    lamp_n;
	logic                          report_n;

	logic                          cur;
	logic [ugs_pkg::CH_W-1:0]      lit_scan;
	logic                          done;
	logic [ugs_pkg::LAMP_W-1:0]    lamp_one;
	logic [ugs_pkg::NOW_W-1:0]     since;

	// per-channel capture registers and near test
	for (genvar c = 0; c < NCH; c++) begin : g_ch
		ugs_pkg::cap_stage_t stage_q;
		logic [CAP_W-1:0]    begin_q;
		logic [CAP_W-1:0]    finish_q;
		logic                cap_hit;

		assign cap_hit = go && (item.op == ugs_pkg::OP_CAPTURE)
			&& (item.channel == ugs_pkg::CH_W'(c));

		// capture progress, further captures once both are in are ignored
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stage_q <= ugs_pkg::CS_NONE;
			end else if (go && (item.op == ugs_pkg::OP_CLEAR)) begin
				stage_q <= ugs_pkg::CS_NONE;
			end else if (cap_hit) begin
				unique case (stage_q)
					ugs_pkg::CS_NONE:  stage_q <= ugs_pkg::CS_START;
					ugs_pkg::CS_START: stage_q <= ugs_pkg::CS_BOTH;
					default:           stage_q <= stage_q;
				endcase
			end
		end

		// latched timer values, read only once both are in
		always_ff @(posedge clk) begin
			if (cap_hit && (stage_q == ugs_pkg::CS_NONE)) begin
				begin_q <= item.capture_value[CAP_W-1:0];
			end
			if (cap_hit && (stage_q == ugs_pkg::CS_START)) begin
				finish_q <= item.capture_value[CAP_W-1:0];
			end
		end

		ugs_near_check #(
			.CAP_W(CAP_W)
		) u_near (
			.stage       (stage_q),
			.echo_begin  (begin_q),
			.echo_finish (finish_q),
			.timer_period(cfg.timer_period),
			.limit       (cfg.limit),
			.near        (near[c])
		);
	end

	// scan in channel order, stopping at the first change of presence
	always_comb begin
		cur      = 1'b0;
		lit_scan = lit_q;
		done     = 1'b0;
		for (int i = 0; i < NCH; i++) begin
			if (!done) begin
				cur = near[i];
				if (near[i]) begin
					lit_scan = ugs_pkg::CH_W'(i);
				end
				if (near[i] != presence_q) begin
					done = 1'b1;
				end
			end
		end
		// channels without capture input are never near
		if (!done && (SENSOR_COUNT > NCH)) begin
			cur = 1'b0;
		end
	end

	// lamp of the last near channel, the fourth channel has none
	assign lamp_one = (32'(lit_scan) < ugs_pkg::LAMP_COUNT)
		? (ugs_pkg::LAMP_W'(1) << lit_scan) : '0;

	assign since = item.now_ms - event_ms_q;

	// next state for one request
	always_comb begin
		presence_n = presence_q;
		phase_n    = phase_q;
		counting_n = counting_q;
		tick_n     = tick_q;
		event_ms_n = event_ms_q;
		lit_n      = lit_q;
		lamp_n     = lamp_q;
		report_n   = 1'b0;
		case (item.op)
			ugs_pkg::OP_TICK: begin
				if (counting_q) begin
					tick_n = tick_q + 1'b1;
				end
			end
			ugs_pkg::OP_EVAL: begin
				lit_n = lit_scan;
				if (since >= ugs_pkg::NOW_W'(cfg.holdoff_ms)) begin
					lamp_n = '0;
					if (cur != presence_q) begin
						if (presence_q && !cur && (phase_q == ugs_pkg::PH_ARMED)) begin
							if (!counting_q) begin
								counting_n = 1'b1;
								tick_n     = '0;
								phase_n    = ugs_pkg::PH_RUNNING;
								event_ms_n = item.now_ms;
								lamp_n     = lamp_one;
							end
						end else if (!presence_q && cur
							&& (phase_q == ugs_pkg::PH_RUNNING)) begin
							if (counting_q) begin
								counting_n = 1'b0;
								phase_n    = ugs_pkg::PH_STOPPED;
								report_n   = 1'b1;
								event_ms_n = item.now_ms;
								lamp_n     = lamp_one;
							end
						end else if (presence_q && !cur
							&& (phase_q == ugs_pkg::PH_STOPPED)) begin
							report_n = 1'b1;
							phase_n  = ugs_pkg::PH_CLEARED;
						end else if (!presence_q && cur
							&& (phase_q == ugs_pkg::PH_CLEARED)) begin
							report_n = 1'b1;
							phase_n  = ugs_pkg::PH_ARMED;
						end
					end
					presence_n = cur;
				end
			end
			ugs_pkg::OP_BUTTON: begin
				if (since > ugs_pkg::NOW_W'(cfg.debounce_ms)) begin
					if (counting_q) begin
						counting_n = 1'b0;
						phase_n    = ugs_pkg::PH_STOPPED;
					end else begin
						counting_n = 1'b1;
						tick_n     = '0;
						phase_n    = ugs_pkg::PH_RUNNING;
					end
					report_n   = 1'b1;
					event_ms_n = item.now_ms;
				end
			end
			default: begin
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presence_q <= 1'b0;
			phase_q    <= ugs_pkg::PH_ARMED;
			counting_q <= 1'b0;
			tick_q     <= '0;
			event_ms_q <= '0;
			lit_q      <= '0;
			lamp_q     <= '0;
		end else if (go) begin
			presence_q <= presence_n;
			phase_q    <= phase_n;
			counting_q <= counting_n;
			tick_q     <= tick_n;
			event_ms_q <= event_ms_n;
			lit_q      <= lit_n;
			lamp_q     <= lamp_n;
		end
	end

	// result shows the state after the request
	assign result.running       = counting_n;
	assign result.elapsed_count = tick_n;
	assign result.phase         = ugs_pkg::phase_code(phase_n);
	assign result.led_mask      = lamp_n;
	assign result.report        = report_n;
	assign result.presence      = presence_n;

`ifndef SYNTH
	// the stopwatch counts exactly in the running phase
	a_run_phase: assert property (@(posedge clk) disable iff (!arst_n)
		counting_q == (phase_q == ugs_pkg::PH_RUNNING))
		else $error("counting flag and sequencer phase disagree");

	// at most one indicator lamp is lit
	a_one_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(lamp_q))
		else $error("more than one lamp lit");

	// the count moves only when a request is processed
	a_tick_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!go |=> $stable(tick_q))
		else $error("stopwatch count moved without a request");

	// captures, ticks and clears never report a time
	a_no_report: assert property (@(posedge clk) disable iff (!arst_n)
		(item.op == ugs_pkg::OP_CAPTURE || item.op == ugs_pkg::OP_TICK
			|| item.op == ugs_pkg::OP_CLEAR) |-> !result.report)
		else $error("report raised by a non-timing request");
`endif

endmodule

[hdl/ultrasonic_gate_stopwatch_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_gate_stopwatch_top
// Timing gate from four ultrasonic echo channels driving a stopwatch.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel (op in tuser; channel, capture value
// and millisecond time in tdata) and each produces exactly one result on the
// m_axis channel: running flag, count in 10 ms ticks, sequencer phase, lamp
// mask, report flag and presence.
// A request is registered at the input, processed combinationally against
// the gate state once the output register is free, and its result registered
// at the output, which drives m_axis_tvalid. One request per cycle is
// sustained while the receiver takes results; the core updates all of its
// state per request (capture registers, presence scan and sequencer).
// When the receiver stalls, the output register holds its result and the
// input register takes one more request, after which s_axis_tready drops
// until the result is taken. Nothing is lost or repeated.
// The cfg channel is always ready and writes a setting by index (0 timer
// period, 1 ticks per cm, 2 near limit in cm, 3 hold-off ms, 4 debounce ms);
// other indexes are ignored. Write settings only while the gate is idle.
// The distance limit in ticks is a register fed from the setting registers.
// Asynchronous reset clears all captures, the sequencer, the stopwatch and
// the lamps, and loads the default settings.
// ----------------------------------------------------------------------------
module ultrasonic_gate_stopwatch_top #(
	parameter int SENSOR_COUNT  = ugs_pkg::SENSOR_COUNT_DEF,
	parameter int CAPTURE_WIDTH = ugs_pkg::CAPTURE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// channel[1:0], capture_value[17:2], now_ms[49:18], zero fill [55:50]
	input  logic [ugs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// op[2:0]
	input  logic [ugs_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
	// result channel
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// running[0], elapsed_count[32:1], phase[34:33], led_mask[37:35],
	// report[38], presence[39]
	output logic [ugs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// settings write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ugs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ugs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [ugs_pkg::PERIOD_W-1:0] period_q;
	logic [ugs_pkg::TICKS_W-1:0]  ticks_q;
	logic [ugs_pkg::NEAR_W-1:0]   near_lim_q;
	logic [ugs_pkg::MS_W-1:0]     holdoff_q;
	logic [ugs_pkg::MS_W-1:0]     debounce_q;
	logic [ugs_pkg::LIMIT_W-1:0]  limit_q;
	ugs_pkg::cfg_t                cfg;

	ugs_pkg::item_t               item_s1;
	logic                         valid_s1;
	logic                         go;
	ugs_pkg::result_t             result;
	logic [ugs_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic                         out_valid_q;

	// settings registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= ugs_pkg::PERIOD_RST;
			ticks_q    <= ugs_pkg::TICKS_RST;
			near_lim_q <= ugs_pkg::NEAR_RST;
			holdoff_q  <= ugs_pkg::HOLDOFF_RST;
			debounce_q <= ugs_pkg::DEBOUNCE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ugs_pkg::CFG_TIMER_PERIOD: period_q   <= cfg_data;
				ugs_pkg::CFG_TICKS_PER_CM: ticks_q    <= cfg_data[ugs_pkg::TICKS_W-1:0];
				ugs_pkg::CFG_NEAR_LIMIT:   near_lim_q <= cfg_data[ugs_pkg::NEAR_W-1:0];
				ugs_pkg::CFG_HOLDOFF:      holdoff_q  <= cfg_data[ugs_pkg::MS_W-1:0];
				ugs_pkg::CFG_DEBOUNCE:     debounce_q <= cfg_data[ugs_pkg::MS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// distance limit in timer ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ugs_pkg::LIMIT_W'(ugs_pkg::NEAR_RST) * ugs_pkg::LIMIT_W'(ugs_pkg::TICKS_RST);
		end else begin
			limit_q <= ugs_pkg::LIMIT_W'(near_lim_q) * ugs_pkg::LIMIT_W'(ticks_q);
		end
	end

	assign cfg.timer_period = period_q;
	assign cfg.limit        = limit_q;
	assign cfg.holdoff_ms   = holdoff_q;
	assign cfg.debounce_ms  = debounce_q;

	// handshake: a request moves on when the output register is free
	assign go            = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.op            <= ugs_pkg::op_t'(s_axis_tuser);
			item_s1.channel       <= s_axis_tdata[1:0];
			item_s1.capture_value <= s_axis_tdata[17:2];
			item_s1.now_ms        <= s_axis_tdata[49:18];
		end
	end

	ugs_core #(
		.SENSOR_COUNT (SENSOR_COUNT),
		.CAPTURE_WIDTH(CAPTURE_WIDTH)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (go),
		.item  (item_s1),
		.cfg   (cfg),
		.result(result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_data_q <= {result.presence, result.report, result.led_mask,
				result.phase, result.elapsed_count, result.running};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
